[rtl/mandelbrot_escape_time_unit_defines.svh]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MET_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MET_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/met_pkg.sv]
// ----------------------------------------------------------------------------
// met_pkg
// Widths, register codes, control words and saturation helper shared by the
// Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package met_pkg;

    // Coordinate format: signed Q4.(COORD_WIDTH-4)
    localparam int COORD_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int FRAC_BITS   = COORD_WIDTH - 4;

    // Full-width products and derived widths
    localparam int PROD_WIDTH   = 2 * COORD_WIDTH;
    localparam int MAG_WIDTH    = PROD_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH    = PROD_WIDTH - FRAC_BITS + 2;
    localparam int THRESH_WIDTH = COORD_WIDTH - 1;
    localparam int CFG_DATA_WIDTH =
        (THRESH_WIDTH > COUNT_WIDTH) ? THRESH_WIDTH : COUNT_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [MAG_WIDTH-1:0]          mag_t;
    typedef logic [THRESH_WIDTH-1:0]       thresh_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_LIMIT  = 1'b1;

    // Register reset values: threshold 4.0, limit 255
    localparam thresh_t THRESH_RESET = THRESH_WIDTH'(64'd4 << FRAC_BITS);
    localparam count_t  LIMIT_RESET  = COUNT_WIDTH'(255);

    // Saturation bounds
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture c, z = c, clear count
        logic mul;     // register x*x, y*y, x*y
        logic step;    // z = z^2 + c, count + 1
        logic finish;  // capture count into the result register
    } met_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic escape;    // |z|^2 above threshold
        logic at_limit;  // count reached the limit
    } met_sts_t;

    // Clamp a widened sum to the signed coordinate range
    function automatic coord_t sat_coord(input sum_t v);
        coord_t r;
        if (v[SUM_WIDTH-1:COORD_WIDTH-1] == {(SUM_WIDTH-COORD_WIDTH+1){v[SUM_WIDTH-1]}})
        begin
            r = coord_t'(v[COORD_WIDTH-1:0]);
        end
        else if (v[SUM_WIDTH-1])
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/met_ctrl.sv]
// ----------------------------------------------------------------------------
// met_ctrl
// Sequencer for the escape-time loop: multiply, evaluate, step or finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_ctrl
    import met_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  met_sts_t sts,
    output met_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.escape || sts.at_limit)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next = cmd.finish;

    // State and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[rtl/met_dp.sv]
// ----------------------------------------------------------------------------
// met_dp
// Datapath: z registers, product registers, magnitude test, z^2 + c update
// with saturation, and the iteration counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_dp
    import met_pkg::*;
(
    input  logic     clk,
    input  met_cmd_t cmd,
    input  coord_t   point_real,
    input  coord_t   point_imag,
    input  thresh_t  threshold,
    input  count_t   limit,
    output met_sts_t sts,
    output count_t   iteration_count
);

    coord_t c_re_reg;
    coord_t c_im_reg;
    coord_t x_reg;
    coord_t x_next;
    coord_t y_reg;
    coord_t y_next;
    prod_t  xx_reg;
    prod_t  yy_reg;
    prod_t  xy_reg;
    prod_t  xx_next;
    prod_t  yy_next;
    prod_t  xy_next;
    count_t cnt_reg;
    count_t cnt_next;
    count_t result_reg;

    logic [PROD_WIDTH-1:0] sq_sum;
    mag_t                  mag;
    prod_t                 diff;
    sum_t                  re_sum;
    sum_t                  im_sum;

    // Full-width products, registered before any further arithmetic
    assign xx_next = x_reg * x_reg;
    assign yy_next = y_reg * y_reg;
    assign xy_next = x_reg * y_reg;

    // |z|^2: both squares are non-negative, so the sum fits unsigned
    assign sq_sum = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign mag    = sq_sum[PROD_WIDTH-1:FRAC_BITS];

    assign sts.escape   = (mag > MAG_WIDTH'(threshold));
    assign sts.at_limit = (cnt_reg == limit);

    // z^2 + c, floored shifts, then saturation
    assign diff   = xx_reg - yy_reg;
    assign re_sum = sum_t'(diff >>> FRAC_BITS) + sum_t'(c_re_reg);
    assign im_sum = sum_t'(xy_reg >>> (FRAC_BITS - 1)) + sum_t'(c_im_reg);

    assign x_next   = sat_coord(re_sum);
    assign y_next   = sat_coord(im_sum);
    assign cnt_next = cnt_reg + COUNT_WIDTH'(1);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_re_reg <= point_real;
            c_im_reg <= point_imag;
            x_reg    <= point_real;
            y_reg    <= point_imag;
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            cnt_reg <= cnt_next;
        end
        if (cmd.mul)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
        if (cmd.finish)
        begin
            result_reg <= cnt_reg;
        end
    end

    assign iteration_count = result_reg;

endmodule

[rtl/mandelbrot_escape_time_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time counter for one complex point c in signed Q4.28: iterates
// z = z^2 + c from z = c until |z|^2 passes the threshold or the limit hits.
//
//   Channel   Handshake            Payload
//   -------   ------------------   -------------------------------
//   point     start / busy         point_real, point_imag
//   result    done (1-cycle)       iteration_count
//   config    cfg_write            cfg_index, cfg_data
//
// For each iteration the unit passes through a multiply state (three 32x32
// products into registers) and an evaluate/update state; the done strobe is
// registered from the final evaluate.
// A new start is taken in the cycle that done is shown.
// Reset returns the sequencer to idle and the registers to 4.0 and 255.
// The result is never held back; it holds from done until the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit
    import met_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  coord_t                     point_real,
    input  coord_t                     point_imag,
    output logic                       done,
    output count_t                     iteration_count,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    thresh_t  threshold_reg;
    thresh_t  threshold_next;
    count_t   limit_reg;
    count_t   limit_next;
    met_cmd_t cmd;
    met_sts_t sts;

    // Configuration register decode
    always_comb
    begin
        threshold_next = threshold_reg;
        limit_next     = limit_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ESCAPE_THRESHOLD: threshold_next = cfg_data[THRESH_WIDTH-1:0];
                REG_ITERATION_LIMIT:  limit_next     = cfg_data[COUNT_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            limit_reg     <= limit_next;
        end
    end

    met_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    met_dp u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .point_real      (point_real),
        .point_imag      (point_imag),
        .threshold       (threshold_reg),
        .limit           (limit_reg),
        .sts             (sts),
        .iteration_count (iteration_count)
    );

endmodule

[rtl/met_checker.sv]
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks on the start/busy/done sequencing of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_unit_defines.svh"

module met_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted word always starts a run
    `MET_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")

    // The result shows up as the unit goes idle
    `MET_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "done while busy")

    // The unit only leaves busy by delivering a result
    `MET_ASSERT_SAME(a_fell_done, clk, rst_n, $fell(busy), done, "busy dropped without done")

    // One result word per run, one cycle wide
    `MET_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);

[tb/mandelbrot_escape_time_unit_test.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit_test
// Self-checking bench for the escape-time unit. Points go in through the
// start/busy port and every done word is checked against a local predictor
// that iterates z = z^2 + c at full product width with saturation. The run
// moves through several threshold/limit settings (both extremes of each),
// with random gaps between points and a few long ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit_test;

    import met_pkg::*;

    // Wide signed type for exact products and sums
    typedef logic signed [2*COORD_WIDTH+1:0] ext_t;

    typedef struct {
        coord_t re;
        coord_t im;
    } point_t;

    typedef struct {
        coord_t re;
        coord_t im;
        count_t count;
    } escape_expect_t;

    localparam longint ONE      = 64'sd1 << FRAC_BITS;
    localparam ext_t   COORD_HI = ext_t'(COORD_MAX);
    localparam ext_t   COORD_LO = ext_t'(COORD_MIN);
    localparam ext_t   MAG_CEIL = ext_t'({COORD_WIDTH{1'b1}});
    localparam int     SHOW_MAX = 40;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       start      = 1'b0;
    logic                       busy;
    coord_t                     point_real = '0;
    coord_t                     point_imag = '0;
    logic                       done;
    count_t                     iteration_count;
    logic                       cfg_write  = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index  = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data   = '0;

    // Register mirror
    thresh_t thresh_model = THRESH_RESET;
    count_t  limit_model  = LIMIT_RESET;

    point_t         pending_points[$];
    escape_expect_t expected_counts[$];
    point_t         next_point;
    escape_expect_t new_expect;
    escape_expect_t oldest;

    int gap_left;
    int burst_left;
    int fail_count;
    int counts_checked;
    int points_sent;
    int limit_runs;
    int instant_escapes;
    int settings_run;

    mandelbrot_escape_time_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .point_real      (point_real),
        .point_imag      (point_imag),
        .done            (done),
        .iteration_count (iteration_count),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Clamp to the signed coordinate range
    function automatic ext_t clamp_coord(ext_t v);
        if (v > COORD_HI)
        begin
            return COORD_HI;
        end
        if (v < COORD_LO)
        begin
            return COORD_LO;
        end
        return v;
    endfunction

    // Iterations before |z|^2 passes the bound, overflows, or the limit is hit
    function automatic count_t escape_count(coord_t c_re, coord_t c_im,
                                            thresh_t bound, count_t limit);
        ext_t   cr;
        ext_t   ci;
        ext_t   x;
        ext_t   y;
        ext_t   xx;
        ext_t   yy;
        ext_t   xy;
        ext_t   mag;
        count_t n;
        bit     running;
        cr      = ext_t'(c_re);
        ci      = ext_t'(c_im);
        x       = cr;
        y       = ci;
        n       = '0;
        running = 1'b1;
        while (running)
        begin
            xx  = x * x;
            yy  = y * y;
            xy  = x * y;
            mag = (xx + yy) >>> FRAC_BITS;
            if (mag > MAG_CEIL || mag > ext_t'(bound) || n == limit)
            begin
                running = 1'b0;
            end
            else
            begin
                n = n + count_t'(1);
                x = clamp_coord(((xx - yy) >>> FRAC_BITS) + cr);
                y = clamp_coord((xy >>> (FRAC_BITS - 1)) + ci);
            end
        end
        return n;
    endfunction

    // Mostly short gaps, some long, with runs of back-to-back words
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(10, 40);
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 64);
    endfunction

    // Random point: mostly around the set, plus raw, tiny and mid-range values
    function automatic point_t random_point();
        point_t p;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            // re in [-2.2, 0.6], im in [-1.3, 1.3]
            p.re = coord_t'(-590558003 + int'($urandom_range(0, 751619277)));
            p.im = coord_t'(-348966093 + int'($urandom_range(0, 697932186)));
        end
        else if (mode <= 7)
        begin
            p.re = coord_t'($urandom);
            p.im = coord_t'($urandom);
        end
        else if (mode == 8)
        begin
            p.re = coord_t'($signed($urandom) >>> $urandom_range(1, 31));
            p.im = coord_t'($signed($urandom) >>> $urandom_range(1, 31));
        end
        else
        begin
            p.re = coord_t'($signed($urandom) >>> $urandom_range(1, 3));
            p.im = coord_t'($signed($urandom) >>> $urandom_range(1, 3));
        end
        return p;
    endfunction

    // Limit register word with junk in the unused upper bits
    function automatic logic [CFG_DATA_WIDTH-1:0] limit_word(int n);
        logic [CFG_DATA_WIDTH-1:0] w;
        w                  = CFG_DATA_WIDTH'($urandom);
        w[COUNT_WIDTH-1:0] = COUNT_WIDTH'(n);
        return w;
    endfunction

    task automatic queue_point(longint re, longint im);
        point_t p;
        p.re = coord_t'(re);
        p.im = coord_t'(im);
        pending_points.push_back(p);
    endtask

    task automatic queue_random(int n);
        repeat (n)
        begin
            pending_points.push_back(random_point());
        end
    endtask

    // Block until every point is taken and every count has come back
    task automatic wait_idle();
        while (pending_points.size() != 0 || start || expected_counts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                             logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ESCAPE_THRESHOLD)
        begin
            thresh_model = data[THRESH_WIDTH-1:0];
        end
        else
        begin
            limit_model = data[COUNT_WIDTH-1:0];
        end
        @(negedge clk);
    endtask

    task automatic report_mismatch(string msg);
        fail_count = fail_count + 1;
        if (fail_count <= SHOW_MAX)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Point driver: holds a word until taken, then waits out a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            point_real <= '0;
            point_imag <= '0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                new_expect.re    = point_real;
                new_expect.im    = point_imag;
                new_expect.count = escape_count(point_real, point_imag,
                                                thresh_model, limit_model);
                expected_counts.push_back(new_expect);
                points_sent = points_sent + 1;
                if (new_expect.count == limit_model)
                begin
                    limit_runs = limit_runs + 1;
                end
                if (new_expect.count == '0)
                begin
                    instant_escapes = instant_escapes + 1;
                end
            end
            if (start && busy)
            begin
                // word still waiting
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_points.size() != 0)
            begin
                next_point = pending_points.pop_front();
                start      <= 1'b1;
                point_real <= next_point.re;
                point_imag <= next_point.im;
                gap_left   <= pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: every done word is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("count %0d with no point pending",
                                          iteration_count));
            end
            else
            begin
                oldest         = expected_counts.pop_front();
                counts_checked = counts_checked + 1;
                if (iteration_count !== oldest.count)
                begin
                    report_mismatch($sformatf("c=(%h,%h) count %0d, predicted %0d",
                                              oldest.re, oldest.im,
                                              iteration_count, oldest.count));
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("timeout with %0d counts outstanding", expected_counts.size());
        $display("status: fail");
        $finish;
    end

    // Phase sequencer
    initial
    begin
        fail_count      = 0;
        counts_checked  = 0;
        points_sent     = 0;
        limit_runs      = 0;
        instant_escapes = 0;
        burst_left      = 0;
        settings_run    = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: 4.0 and 255; corners and known orbits
        queue_point(0, 0);
        queue_point(longint'(COORD_MAX), longint'(COORD_MAX));
        queue_point(longint'(COORD_MIN), longint'(COORD_MIN));
        queue_point(longint'(COORD_MIN), 0);
        queue_point(0, longint'(COORD_MAX));
        queue_point(-2 * ONE, 0);               // |z|^2 sits exactly on 4.0
        queue_point(2 * ONE, 0);
        queue_point(2 * ONE - 1, 0);
        queue_point(ONE / 4, 0);                // cusp, slow convergence
        queue_point(-3 * ONE / 4, ONE / 10);    // neck, long escape
        queue_point(0, ONE);                    // period-2 orbit
        queue_point(0, -2 * ONE);
        queue_point(1, -1);                     // one LSB each way
        queue_point(-3 * ONE / 2, 1);
        queue_random(300);
        wait_idle();

        // Widest threshold so coordinates can saturate; deeper limit
        write_reg(REG_ESCAPE_THRESHOLD, {THRESH_WIDTH{1'b1}});
        write_reg(REG_ITERATION_LIMIT, limit_word(1000));
        settings_run = settings_run + 1;
        queue_random(200);
        wait_idle();

        // Zero threshold, full limit: only the origin runs all the way
        write_reg(REG_ESCAPE_THRESHOLD, '0);
        write_reg(REG_ITERATION_LIMIT, limit_word(2 ** COUNT_WIDTH - 1));
        settings_run = settings_run + 1;
        queue_point(0, 0);
        repeat (20)
        begin
            queue_point(($urandom_range(0, 1) ? -1 : 1) *
                        (ONE + longint'($urandom_range(0, 32'(7 * ONE - 1)))),
                        longint'($signed($urandom)));
        end
        wait_idle();

        // Zero limit: every count is zero
        write_reg(REG_ITERATION_LIMIT, limit_word(0));
        write_reg(REG_ESCAPE_THRESHOLD, CFG_DATA_WIDTH'($urandom));
        settings_run = settings_run + 1;
        queue_random(40);
        wait_idle();

        // Random threshold and small random limit
        write_reg(REG_ESCAPE_THRESHOLD,
                  CFG_DATA_WIDTH'($urandom_range(32'(ONE), 32'({THRESH_WIDTH{1'b1}}))));
        write_reg(REG_ITERATION_LIMIT, limit_word($urandom_range(1, 300)));
        settings_run = settings_run + 1;
        queue_random(250);
        wait_idle();

        // Back to reset values
        write_reg(REG_ESCAPE_THRESHOLD, CFG_DATA_WIDTH'(THRESH_RESET));
        write_reg(REG_ITERATION_LIMIT, limit_word(int'(LIMIT_RESET)));
        settings_run = settings_run + 1;
        queue_random(140);
        wait_idle();
        queue_random(140);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("%0d points over %0d register settings, %0d counts checked",
                 points_sent, settings_run, counts_checked);
        $display("%0d ran to the limit, %0d escaped at once, %0d mismatches",
                 limit_runs, instant_escapes, fail_count);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
